@@ sv/mic_pkg.sv @@
// Shared types and constants for the masked image centroid block.
// No dependencies; compiled first.
`default_nettype none

package mic_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned THR_W  = 8;
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FLUSH,
    ST_SWEEP,
    ST_TAIL,
    ST_DIVX,
    ST_DIVY,
    ST_OUT
  } state_t;

  // Controls into the projection store for one cycle.
  typedef struct packed {
    logic pix;
    logic lit;
    logic row_end;
    logic sweep;
  } proj_ctl_t;

endpackage

`default_nettype wire

@@ sv/mic_ifs.sv @@
// Valid/ready channel interfaces for pixels in and centroid results out.
// Depends on mic_pkg.
`default_nettype none

interface mic_in_if;
  logic                      valid;
  logic                      ready;
  logic [mic_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mic_out_if #(
  parameter int unsigned CW = 19,
  parameter int unsigned XW = 10,
  parameter int unsigned YW = 10,
  parameter int unsigned TW = 21
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;
  logic [XW:0]   sigma_x_halves;
  logic [YW:0]   sigma_y_halves;
  logic [XW-1:0] left_col;
  logic [XW:0]   right_col;
  logic [YW-1:0] bottom_row;
  logic [YW:0]   top_row;
  logic [TW-1:0] lit_count;
  logic          empty_frame;
  modport source (output valid, output center_x, output center_y, output sigma_x_halves,
                  output sigma_y_halves, output left_col, output right_col,
                  output bottom_row, output top_row, output lit_count,
                  output empty_frame, input ready);
  modport sink   (input valid, input center_x, input center_y, input sigma_x_halves,
                  input sigma_y_halves, input left_col, input right_col,
                  input bottom_row, input top_row, input lit_count,
                  input empty_frame, output ready);
endinterface

`default_nettype wire

@@ sv/mic_cfg.sv @@
// APB-style register file: frame width, frame height and lit threshold.
// Depends on mic_pkg.
`default_nettype none

module mic_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mic_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mic_pkg::CFG_DW-1:0] pwdata,
  output logic      [mic_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [mic_pkg::SIZE_W-1:0] width_r,
  output logic      [mic_pkg::SIZE_W-1:0] height_r,
  output logic      [mic_pkg::THR_W-1:0]  thresh_r
);
  import mic_pkg::*;

  cfg_reg_t idx;
  logic     wr;

  assign idx    = cfg_reg_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1024);
      height_r <= SIZE_W'(1024);
      thresh_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        REG_THRESH: thresh_r <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = CFG_DW'(width_r);
      REG_HEIGHT: prdata = CFG_DW'(height_r);
      REG_THRESH: prdata = CFG_DW'(thresh_r);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mic_proj.sv @@
// Column and row projection memories with pixel read-modify-write and sweep.
// Depends on mic_pkg.
`default_nettype none

module mic_proj #(
  parameter int unsigned MW  = 1024,
  parameter int unsigned MH  = 1024,
  parameter int unsigned XW  = 10,
  parameter int unsigned YW  = 10,
  parameter int unsigned CCW = 11,
  parameter int unsigned RCW = 11,
  parameter int unsigned SIW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mic_pkg::proj_ctl_t ctl,
  input  wire logic [XW-1:0]      col,
  input  wire logic [YW-1:0]      row,
  input  wire logic [SIW-1:0]     swi,
  output logic      [CCW-1:0]     col_cnt,
  output logic      [RCW-1:0]     row_cnt
);
  import mic_pkg::*;

  logic [CCW-1:0] col_mem [MW];
  logic [RCW-1:0] row_mem [MH];

  logic           s_v_r, s_lit_r, s_fwd_r;
  logic [XW-1:0]  s_addr_r;
  logic [CCW-1:0] wlast_r, col_rd_r, s_wd;
  logic [RCW-1:0] row_rd_r, row_acc_r, row_sum;
  logic           sw_in_x, sw_in_y;
  logic           col_we, row_we;
  logic [XW-1:0]  col_ra, col_wa;
  logic [CCW-1:0] col_wd;
  logic [YW-1:0]  row_wa;
  logic [RCW-1:0] row_wd;

  assign sw_in_x = 32'(swi) < MW;
  assign sw_in_y = 32'(swi) < MH;

  // Forward the value written last cycle when the same column comes back.
  assign s_wd   = (s_fwd_r ? wlast_r : col_rd_r) + CCW'(s_lit_r);
  assign col_ra = ctl.sweep ? swi[XW-1:0] : col;
  assign col_we = s_v_r | (ctl.sweep & sw_in_x);
  assign col_wa = s_v_r ? s_addr_r : swi[XW-1:0];
  assign col_wd = s_v_r ? s_wd : '0;

  assign row_sum = row_acc_r + RCW'(ctl.lit);
  assign row_we  = (ctl.pix & ctl.row_end) | (ctl.sweep & sw_in_y);
  assign row_wa  = ctl.pix ? row : swi[YW-1:0];
  assign row_wd  = ctl.pix ? row_sum : '0;

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rd_r <= row_mem[swi[YW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r     <= 1'b0;
      s_fwd_r   <= 1'b0;
      row_acc_r <= '0;
    end else begin
      s_v_r   <= ctl.pix;
      s_fwd_r <= ctl.pix & s_v_r & (s_addr_r == col);
      if (ctl.pix) row_acc_r <= ctl.row_end ? '0 : row_sum;
    end
  end

  always_ff @(posedge clk) begin
    s_addr_r <= col;
    s_lit_r  <= ctl.lit;
    wlast_r  <= s_wd;
  end

  assign col_cnt = col_rd_r;
  assign row_cnt = row_rd_r;

endmodule

`default_nettype wire

@@ sv/mic_axis.sv @@
// Per-axis sweep reduction: weighted index sum and first lit run.
// Depends on mic_pkg.
`default_nettype none

module mic_axis #(
  parameter int unsigned SIW = 10,
  parameter int unsigned IW  = 10,
  parameter int unsigned CNW = 11,
  parameter int unsigned AW  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           clr,
  input  wire logic           vld,
  input  wire logic [SIW-1:0] idx,
  input  wire logic [CNW-1:0] cnt,
  input  wire logic [IW:0]    n,
  output logic      [AW-1:0]  acc,
  output logic      [IW-1:0]  lo,
  output logic      [IW:0]    hi
);
  import mic_pkg::*;

  logic          in_rng, use_it;
  logic          found_r, closed_r, prod_v_r;
  logic [IW-1:0] first_r;
  logic [IW:0]   after_r;
  logic [AW-1:0] prod_r, acc_r;
  logic [SIW:0]  weight;

  assign in_rng = 32'(idx) < 32'(n);
  assign use_it = vld & in_rng;
  assign weight = (SIW+1)'(idx) + (SIW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      closed_r <= 1'b0;
      prod_v_r <= 1'b0;
    end else if (clr) begin
      found_r  <= 1'b0;
      closed_r <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= use_it;
      if (use_it) begin
        if (!found_r && cnt != '0) found_r <= 1'b1;
        else if (found_r && !closed_r && cnt == '0) closed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= AW'(cnt * weight);
    if (clr) begin
      acc_r   <= '0;
      after_r <= n;
      first_r <= '0;
    end else begin
      if (prod_v_r) acc_r <= acc_r + prod_r;
      if (use_it) begin
        if (!found_r && cnt != '0) first_r <= idx[IW-1:0];
        else if (found_r && !closed_r && cnt == '0) after_r <= (IW+1)'(idx);
      end
    end
  end

  assign acc = acc_r;
  assign lo  = found_r ? first_r : '0;
  assign hi  = found_r ? after_r : '0;

endmodule

`default_nettype wire

@@ sv/mic_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on mic_pkg.
`default_nettype none

module mic_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quot
);
  import mic_pkg::*;

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r;
  logic [DW:0]     rem_r, sh;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r, ge;

  assign sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? sh - {1'b0, den} : sh;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

@@ sv/masked_image_centroid.sv @@
// Masked image centroid: one pixel per cycle while in ready is high, thresholded,
// projected onto column and row memories. Frame end: a flush state, a sweep over
// max(MAX_WIDTH, MAX_HEIGHT) memory entries, a pipeline tail, two serial divisions
// (skipped for a frame with no lit pixels), then a load into the output register.
// After reset a clearing pass over max(MAX_WIDTH, MAX_HEIGHT) entries runs with in
// ready low; configuration writes are taken throughout.
`default_nettype none

module masked_image_centroid #(
  parameter int unsigned MAX_WIDTH        = 1024,
  parameter int unsigned MAX_HEIGHT       = 1024,
  parameter int unsigned CENTER_FRAC_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  mic_in_if.sink                          in_ch,
  mic_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mic_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mic_pkg::CFG_DW-1:0] pwdata,
  output logic      [mic_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import mic_pkg::*;

  localparam int unsigned MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_HEIGHT);
  localparam int unsigned SIW  = $clog2(MAXD);
  localparam int unsigned CCW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RCW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned AW   = TW + $clog2(MAXD + 1);
  localparam int unsigned NW   = AW + CENTER_FRAC_BITS;
  localparam int unsigned CW   = $clog2((MAXD << CENTER_FRAC_BITS) + 1);

  logic [SIZE_W-1:0] width_r, height_r;
  logic [THR_W-1:0]  thresh_r;

  state_t         state_r, state_nxt;
  logic [XW-1:0]  col_r;
  logic [YW-1:0]  row_r;
  logic [SIW-1:0] swi_r;
  logic [1:0]     tail_r;
  logic [TW-1:0]  total_r;
  logic           rvld_r;
  logic [SIW-1:0] ridx_r;
  logic [CW-1:0]  cx_r;

  logic [XW:0]    wc;
  logic [YW:0]    hc;
  logic           accept, lit, col_end, frame_end, sweep_last;
  logic           axis_clr, div_start, load_out;
  proj_ctl_t      ctl;

  logic [CCW-1:0] col_cnt;
  logic [RCW-1:0] row_cnt;
  logic [AW-1:0]  acc_x, acc_y;
  logic [XW-1:0]  lo_x;
  logic [XW:0]    hi_x;
  logic [YW-1:0]  lo_y;
  logic [YW:0]    hi_y;
  logic [NW-1:0]  num, quot;
  logic           div_done;

  logic           out_valid_r, out_empty_r;
  logic [CW-1:0]  out_cx_r, out_cy_r;
  logic [XW:0]    out_sx_r, out_right_r;
  logic [YW:0]    out_sy_r, out_top_r;
  logic [XW-1:0]  out_left_r;
  logic [YW-1:0]  out_bottom_r;
  logic [TW-1:0]  out_lit_r;

  mic_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .width_r, .height_r, .thresh_r
  );

  // Zero acts as one, oversize acts as the maximum.
  assign wc = (width_r == '0) ? (XW+1)'(1) :
              (32'(width_r) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(width_r);
  assign hc = (height_r == '0) ? (YW+1)'(1) :
              (32'(height_r) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(height_r);

  assign in_ch.ready = (state_r == ST_RUN);
  assign accept      = in_ch.valid & in_ch.ready;
  assign lit         = in_ch.pixel > thresh_r;
  assign col_end     = ((XW+1)'(col_r) + (XW+1)'(1)) >= wc;
  assign frame_end   = col_end & (((YW+1)'(row_r) + (YW+1)'(1)) >= hc);
  assign sweep_last  = swi_r == SIW'(MAXD - 1);

  assign ctl.pix     = accept;
  assign ctl.lit     = accept & lit;
  assign ctl.row_end = col_end;
  assign ctl.sweep   = (state_r == ST_SWEEP) | (state_r == ST_CLEAR);

  mic_proj #(
    .MW(MAX_WIDTH), .MH(MAX_HEIGHT), .XW(XW), .YW(YW), .CCW(CCW), .RCW(RCW), .SIW(SIW)
  ) u_proj (
    .clk, .rst_n, .ctl, .col(col_r), .row(row_r), .swi(swi_r), .col_cnt, .row_cnt
  );

  mic_axis #(.SIW(SIW), .IW(XW), .CNW(CCW), .AW(AW)) u_axis_x (
    .clk, .rst_n, .clr(axis_clr), .vld(rvld_r), .idx(ridx_r), .cnt(col_cnt), .n(wc),
    .acc(acc_x), .lo(lo_x), .hi(hi_x)
  );

  mic_axis #(.SIW(SIW), .IW(YW), .CNW(RCW), .AW(AW)) u_axis_y (
    .clk, .rst_n, .clr(axis_clr), .vld(rvld_r), .idx(ridx_r), .cnt(row_cnt), .n(hc),
    .acc(acc_y), .lo(lo_y), .hi(hi_y)
  );

  // Numerator: sum shifted by the fraction bits plus half the divisor.
  assign num = ((NW'((state_r == ST_DIVX) ? acc_y : acc_x)) << CENTER_FRAC_BITS)
               + NW'(total_r >> 1);

  mic_div #(.NW(NW), .DW(TW)) u_div (
    .clk, .rst_n, .start(div_start), .num, .den(total_r), .done(div_done), .quot
  );

  always_comb begin
    state_nxt = state_r;
    axis_clr  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_CLEAR: if (sweep_last) state_nxt = ST_RUN;
      ST_RUN:   if (accept && frame_end) state_nxt = ST_FLUSH;
      ST_FLUSH: begin
        axis_clr  = 1'b1;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: if (sweep_last) state_nxt = ST_TAIL;
      ST_TAIL: begin
        if (tail_r == 2'd2) begin
          if (total_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: if (div_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      swi_r       <= '0;
      tail_r      <= '0;
      total_r     <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rvld_r <= (state_r == ST_SWEEP);
      if (ctl.sweep) swi_r <= sweep_last ? '0 : swi_r + SIW'(1);
      tail_r <= (state_r == ST_TAIL) ? tail_r + 2'd1 : 2'd0;
      if (accept) begin
        total_r <= total_r + TW'(lit);
        if (col_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + YW'(1);
        end else begin
          col_r <= col_r + XW'(1);
        end
      end
      if (load_out) total_r <= '0;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= swi_r;
    if (state_r == ST_DIVX && div_done) cx_r <= quot[CW-1:0];
    if (load_out) begin
      out_empty_r <= (total_r == '0);
      out_lit_r   <= total_r;
      if (total_r == '0) begin
        out_cx_r     <= '0;
        out_cy_r     <= '0;
        out_sx_r     <= '0;
        out_sy_r     <= '0;
        out_left_r   <= '0;
        out_right_r  <= '0;
        out_bottom_r <= '0;
        out_top_r    <= '0;
      end else begin
        out_cx_r     <= cx_r;
        out_cy_r     <= quot[CW-1:0];
        out_sx_r     <= hi_x - (XW+1)'(lo_x);
        out_sy_r     <= hi_y - (YW+1)'(lo_y);
        out_left_r   <= lo_x;
        out_right_r  <= hi_x;
        out_bottom_r <= lo_y;
        out_top_r    <= hi_y;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.center_x       = out_cx_r;
  assign out_ch.center_y       = out_cy_r;
  assign out_ch.sigma_x_halves = out_sx_r;
  assign out_ch.sigma_y_halves = out_sy_r;
  assign out_ch.left_col       = out_left_r;
  assign out_ch.right_col      = out_right_r;
  assign out_ch.bottom_row     = out_bottom_r;
  assign out_ch.top_row        = out_top_r;
  assign out_ch.lit_count      = out_lit_r;
  assign out_ch.empty_frame    = out_empty_r;

endmodule

`default_nettype wire

@@ sv/mic_chk.sv @@
// Port-level checks for the masked image centroid, bound to the top level.
// Depends on masked_image_centroid.
`default_nettype none

module mic_chk #(
  parameter int unsigned CW = 19,
  parameter int unsigned XW = 10,
  parameter int unsigned TW = 21
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic          empty_frame,
  input wire logic [TW-1:0] lit_count,
  input wire logic [CW-1:0] center_x,
  input wire logic [XW:0]   sigma_x_halves,
  input wire logic [XW-1:0] left_col,
  input wire logic [XW:0]   right_col
);

  // Clearing pass holds off pixels right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("pixel transfer open during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_frame |-> lit_count == '0 && center_x == '0 && right_col == '0)
    else $error("empty frame with non-zero fields");

  a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty_frame |-> lit_count != '0)
    else $error("lit frame reports no lit pixels");

  a_sigma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sigma_x_halves == (right_col - (XW+1)'(left_col)))
    else $error("sigma_x does not match column edges");

endmodule

bind masked_image_centroid mic_chk #(.CW(CW), .XW(XW), .TW(TW)) u_mic_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .empty_frame    (out_ch.empty_frame),
  .lit_count      (out_ch.lit_count),
  .center_x       (out_ch.center_x),
  .sigma_x_halves (out_ch.sigma_x_halves),
  .left_col       (out_ch.left_col),
  .right_col      (out_ch.right_col)
);

`default_nettype wire
